// File: design/msss_pkg.sv
// Shared types and constants for the multi-stack shared-store block.
`default_nettype none
package msss_pkg;

	localparam int NUM_STACKS_DEF  = 4;
	localparam int STORE_DEPTH_DEF = 16;

	localparam logic signed [31:0] INT_MAX = 32'sh7FFF_FFFF;

	localparam logic OP_PUSH = 1'b0;
	localparam logic OP_POP  = 1'b1;

	localparam logic [1:0] ST_DONE  = 2'd0;
	localparam logic [1:0] ST_FULL  = 2'd1;
	localparam logic [1:0] ST_EMPTY = 2'd2;

	typedef struct packed {
		logic               op;
		logic [1:0]         stack_sel;
		logic signed [31:0] push_value;
	} req_t;

	typedef struct packed {
		logic signed [31:0] pop_value;
		logic [1:0]         status;
	} rsp_t;

	typedef struct packed {
		logic capture;
		logic issue_rd;
		logic commit;
		logic refuse;
	} ctl_cmd_t;

	typedef struct packed {
		logic refused;
	} ctl_stat_t;

endpackage
`default_nettype wire

// File: design/multi_stack_shared_store.sv
// The done strobe is registered from the commit state for a completed push or pop,
// and from the lookup state for a refused one (full store or empty stack).
// The block takes no new transaction while busy with one; its sequence is set by the
// registered reads of the head table and then of the link and value stores.
// Reset clears the stack heads and free list at once; the block is ready right away.
// The done strobe is high for one cycle; the result register holds until the next result, as the receiver cannot stall.
`default_nettype none
module multi_stack_shared_store
	import msss_pkg::*;
#(
	parameter int NUM_STACKS  = NUM_STACKS_DEF,
	parameter int STORE_DEPTH = STORE_DEPTH_DEF
) (
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic start,
	output logic      busy,
	input  wire req_t request,
	output logic      done,
	output rsp_t      response
);

	ctl_cmd_t  cmd;
	ctl_stat_t stat;

	msss_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.busy   (busy),
		.cmd    (cmd),
		.stat   (stat)
	);

	msss_dp #(
		.NUM_STACKS  (NUM_STACKS),
		.STORE_DEPTH (STORE_DEPTH)
	) u_dp (
		.clk      (clk),
		.arst_n   (arst_n),
		.cmd      (cmd),
		.stat     (stat),
		.request  (request),
		.done     (done),
		.response (response)
	);

endmodule
`default_nettype wire

// File: design/msss_ctrl.sv
// Sequencer for one stack transaction: look up, then read the slot and commit, or refuse.
`default_nettype none
module msss_ctrl
	import msss_pkg::*;
(
	input  wire logic      clk,
	input  wire logic      arst_n,
	input  wire logic      start,
	output logic           busy,
	output ctl_cmd_t       cmd,
	input  wire ctl_stat_t stat
);

	localparam logic [1:0] S_IDLE   = 2'd0;
	localparam logic [1:0] S_LOOK   = 2'd1;
	localparam logic [1:0] S_COMMIT = 2'd2;

	logic [1:0] state_q;
	logic [1:0] state_d;

	assign busy = (state_q != S_IDLE);

	always_comb begin
		state_d = state_q;
		cmd     = '0;
		unique case (state_q)
			S_IDLE: begin
				if (start) begin
					cmd.capture = 1'b1;
					state_d     = S_LOOK;
				end
			end
			S_LOOK: begin
				if (stat.refused) begin
					cmd.refuse = 1'b1;
					state_d    = S_IDLE;
				end else begin
					cmd.issue_rd = 1'b1;
					state_d      = S_COMMIT;
				end
			end
			S_COMMIT: begin
				cmd.commit = 1'b1;
				state_d    = S_IDLE;
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |=> (state_q == S_LOOK))
		else $error("accepted transaction did not enter lookup");

	assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_COMMIT) |=> (state_q == S_IDLE))
		else $error("commit did not return to idle");

	assert property (@(posedge clk) disable iff (!arst_n)
		$onehot0(cmd))
		else $error("more than one datapath command in a cycle");

endmodule
`default_nettype wire

// File: design/msss_dp.sv
// Datapath: head table, link and value stores, free list and result register.
`default_nettype none
module msss_dp
	import msss_pkg::*;
#(
	parameter int NUM_STACKS  = NUM_STACKS_DEF,
	parameter int STORE_DEPTH = STORE_DEPTH_DEF
) (
	input  wire logic     clk,
	input  wire logic     arst_n,
	input  wire ctl_cmd_t cmd,
	output ctl_stat_t     stat,
	input  wire req_t     request,
	output logic          done,
	output rsp_t          response
);

	localparam int PW = $clog2(STORE_DEPTH + 1);
	localparam int AW = $clog2(STORE_DEPTH);
	localparam int SW = (NUM_STACKS > 1) ? $clog2(NUM_STACKS) : 1;
	localparam logic [PW-1:0] NULL_PTR = PW'(STORE_DEPTH);

	logic [PW-1:0]      head_mem  [NUM_STACKS];
	logic [PW-1:0]      link_mem  [STORE_DEPTH];
	logic signed [31:0] value_mem [STORE_DEPTH];

	logic [NUM_STACKS-1:0] head_vld_q;
	logic [PW-1:0]         free_head_q;
	logic [PW-1:0]         fresh_q;
	logic                  done_q;

	req_t               req_q;
	logic [PW-1:0]      head_rd_q;
	logic               head_vld_rd_q;
	logic [PW-1:0]      link_rd_q;
	logic signed [31:0] val_rd_q;
	rsp_t               rsp_q;

	logic [SW-1:0] in_idx;
	logic [SW-1:0] sel_idx;
	logic          sel_ok;
	logic [PW-1:0] head_eff;
	logic [PW-1:0] slot;
	logic [AW-1:0] slot_a;
	logic          is_pop;

	assign in_idx   = SW'(request.stack_sel);
	assign sel_idx  = SW'(req_q.stack_sel);
	assign sel_ok   = (32'(req_q.stack_sel) < 32'(NUM_STACKS));
	assign is_pop   = (req_q.op == OP_POP);
	assign head_eff = head_vld_rd_q ? head_rd_q : NULL_PTR;
	assign slot     = is_pop ? head_eff : free_head_q;
	assign slot_a   = slot[AW-1:0];

	always_comb begin
		if (is_pop) begin
			stat.refused = !sel_ok || (head_eff == NULL_PTR);
		end else begin
			stat.refused = !sel_ok || (free_head_q == NULL_PTR);
		end
	end

	// Memories and payload registers; no reset.
	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			req_q         <= request;
			head_rd_q     <= head_mem[in_idx];
			head_vld_rd_q <= head_vld_q[in_idx];
		end
		if (cmd.issue_rd) begin
			link_rd_q <= link_mem[slot_a];
			val_rd_q  <= value_mem[slot_a];
		end
		if (cmd.commit) begin
			if (is_pop) begin
				head_mem[sel_idx] <= link_rd_q;
				link_mem[slot_a]  <= free_head_q;
			end else begin
				head_mem[sel_idx] <= slot;
				link_mem[slot_a]  <= head_eff;
				value_mem[slot_a] <= req_q.push_value;
			end
		end
		if (cmd.refuse) begin
			rsp_q.status    <= is_pop ? ST_EMPTY : ST_FULL;
			rsp_q.pop_value <= is_pop ? INT_MAX : 32'sd0;
		end else if (cmd.commit) begin
			rsp_q.status    <= ST_DONE;
			rsp_q.pop_value <= is_pop ? val_rd_q : 32'sd0;
		end
	end

	// Slots at or above fresh_q were never handed out; they form the tail of the
	// free list in order, so their links are implied and never used.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_vld_q  <= '0;
			free_head_q <= '0;
			fresh_q     <= '0;
			done_q      <= 1'b0;
		end else begin
			done_q <= cmd.commit || cmd.refuse;
			if (cmd.commit) begin
				if (is_pop) begin
					free_head_q <= slot;
				end else begin
					head_vld_q[sel_idx] <= 1'b1;
					if (slot == fresh_q) begin
						free_head_q <= fresh_q + PW'(1);
						fresh_q     <= fresh_q + PW'(1);
					end else begin
						free_head_q <= link_rd_q;
					end
				end
			end
		end
	end

	assign done     = done_q;
	assign response = rsp_q;

	assert property (@(posedge clk) disable iff (!arst_n)
		free_head_q <= fresh_q)
		else $error("free list head beyond the untouched region");

	assert property (@(posedge clk) disable iff (!arst_n)
		fresh_q <= NULL_PTR)
		else $error("untouched-slot count beyond store depth");

	assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.commit && !is_pop) |-> (free_head_q != NULL_PTR))
		else $error("push committed with an empty free list");

	assert property (@(posedge clk) disable iff (!arst_n)
		done_q |-> (rsp_q.status == ST_DONE || rsp_q.status == ST_FULL
			|| rsp_q.status == ST_EMPTY))
		else $error("result strobe with an undefined status");

endmodule
`default_nettype wire

// File: test/tb_top.sv
`timescale 1ns / 100ps
// Self-checking testbench for the shared-store multi-stack block.
module tb_top;
	import msss_pkg::*;

	localparam int NULL_SLOT        = STORE_DEPTH_DEF;
	localparam int CYCLE_LIMIT      = 200000;
	localparam int RANDOM_PER_PHASE = 200;

	logic clk    = 1'b0;
	logic arst_n = 1'b0;
	logic start  = 1'b0;
	req_t request = '0;
	logic busy;
	logic done;
	rsp_t response;

	// Predicted contents of the block: slot values, slot links, stack tops and free list.
	logic signed [31:0] slot_values [STORE_DEPTH_DEF];
	int                 slot_links  [STORE_DEPTH_DEF];
	int                 stack_tops  [NUM_STACKS_DEF];
	int                 free_top;

	rsp_t pending_replies [$];
	int   error_count = 0;
	int   cycle_count = 0;

	multi_stack_shared_store dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (start),
		.busy     (busy),
		.request  (request),
		.done     (done),
		.response (response)
	);

	always #1 clk = ~clk;

	function automatic void clear_stacks();
		for (int i = 0; i < STORE_DEPTH_DEF; i++) begin
			slot_links[i]  = i + 1;
			slot_values[i] = '0;
		end
		for (int i = 0; i < NUM_STACKS_DEF; i++) begin
			stack_tops[i] = NULL_SLOT;
		end
		free_top = 0;
	endfunction

	function automatic rsp_t apply_stack_op(input req_t r);
		rsp_t reply;
		int   slot;
		int   sel;
		sel             = int'(r.stack_sel);
		reply.pop_value = 32'sd0;
		reply.status    = ST_DONE;
		if (r.op == OP_PUSH) begin
			if (sel >= NUM_STACKS_DEF || free_top == NULL_SLOT) begin
				reply.status = ST_FULL;
			end else begin
				slot              = free_top;
				free_top          = slot_links[slot];
				slot_values[slot] = r.push_value;
				slot_links[slot]  = stack_tops[sel];
				stack_tops[sel]   = slot;
			end
		end else begin
			if (sel >= NUM_STACKS_DEF || stack_tops[sel] == NULL_SLOT) begin
				reply.pop_value = INT_MAX;
				reply.status    = ST_EMPTY;
			end else begin
				slot             = stack_tops[sel];
				stack_tops[sel]  = slot_links[slot];
				slot_links[slot] = free_top;
				free_top         = slot;
				reply.pop_value  = slot_values[slot];
			end
		end
		return reply;
	endfunction

	function automatic req_t make_push(input int sel, input logic signed [31:0] value);
		req_t r;
		r.op         = OP_PUSH;
		r.stack_sel  = 2'(sel);
		r.push_value = value;
		return r;
	endfunction

	function automatic req_t make_pop(input int sel);
		req_t r;
		r.op         = OP_POP;
		r.stack_sel  = 2'(sel);
		r.push_value = $urandom;
		return r;
	endfunction

	// Random value with the extremes mixed in often.
	function automatic logic signed [31:0] pick_value();
		case ($urandom_range(7))
			0: return 32'sh8000_0000;
			1: return INT_MAX;
			2: return 32'sd0;
			3: return -32'sd1;
			default: return $urandom;
		endcase
	endfunction

	task automatic report_mismatch(input string msg);
		$display("MISMATCH cycle %0d: %s", cycle_count, msg);
		error_count++;
	endtask

	// Called at a rising edge; returns at the edge where the transaction is accepted.
	task automatic send_op(input req_t r);
		start   <= 1'b1;
		request <= r;
		@(posedge clk);
		while (busy !== 1'b0) @(posedge clk);
		pending_replies.push_back(apply_stack_op(r));
	endtask

	task automatic maybe_idle(input int idle_pct);
		if ($urandom_range(99) < idle_pct) begin
			start <= 1'b0;
			repeat ($urandom_range(1, 4)) @(posedge clk);
		end
	endtask

	task automatic drain_replies();
		start <= 1'b0;
		while (pending_replies.size() != 0) @(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic test_empty_pops();
		for (int s = 0; s < NUM_STACKS_DEF; s++) begin
			send_op(make_pop(s));
		end
	endtask

	// Fill every slot, the first six with extreme values, push once more into a full store, then pop and push again.
	task automatic test_fill_and_refuse();
		logic signed [31:0] edge_vals [6];
		edge_vals = '{32'sh8000_0000, INT_MAX, 32'sd0, -32'sd1, 32'shAAAA_AAAA, 32'sh5555_5555};
		for (int i = 0; i < STORE_DEPTH_DEF; i++) begin
			send_op(make_push(i % NUM_STACKS_DEF, (i < 6) ? edge_vals[i] : $urandom));
		end
		send_op(make_push($urandom_range(NUM_STACKS_DEF - 1), pick_value()));
		send_op(make_pop(0));
		send_op(make_push(1, pick_value()));
	endtask

	// Bursts lean toward pushes or pops, or stay balanced, so the store swings between full and empty.
	task automatic test_random_traffic(input int idle_pct);
		int push_pct;
		push_pct = 50;
		for (int n = 0; n < RANDOM_PER_PHASE; n++) begin
			if (n % 40 == 0) begin
				case ($urandom_range(2))
					0: push_pct = 15;
					1: push_pct = 50;
					default: push_pct = 85;
				endcase
			end
			if ($urandom_range(99) < push_pct) begin
				send_op(make_push($urandom_range(NUM_STACKS_DEF - 1), pick_value()));
			end else begin
				send_op(make_pop($urandom_range(NUM_STACKS_DEF - 1)));
			end
			maybe_idle(idle_pct);
		end
	endtask

	always @(posedge clk) begin
		rsp_t want;
		if (arst_n && done === 1'b1) begin
			if (pending_replies.size() == 0) begin
				report_mismatch($sformatf("result %h with nothing pending", response));
			end else begin
				want = pending_replies.pop_front();
				if (response.pop_value !== want.pop_value) begin
					report_mismatch($sformatf("pop_value %h expected %h",
						response.pop_value, want.pop_value));
				end
				if (response.status !== want.status) begin
					report_mismatch($sformatf("status %0d expected %0d",
						response.status, want.status));
				end
			end
		end
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("tb_top NOT OK");
			$finish;
		end
	end

	initial begin
		clear_stacks();
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_empty_pops();
		drain_replies();
		test_fill_and_refuse();
		drain_replies();
		test_random_traffic(0);
		drain_replies();
		test_random_traffic(46);
		drain_replies();
		test_random_traffic(34);
		drain_replies();
		repeat (8) @(posedge clk);
		if (pending_replies.size() != 0) begin
			report_mismatch($sformatf("%0d results never arrived", pending_replies.size()));
		end
		if (error_count == 0) begin
			$display("tb_top OK");
		end else begin
			$display("tb_top NOT OK");
		end
		$finish;
	end

endmodule

// File: filelist.f
design/msss_pkg.sv
design/msss_ctrl.sv
design/msss_dp.sv
design/multi_stack_shared_store.sv
test/tb_top.sv
